[src/srtf_pkg.sv]
// shared types and constants for the shortest-remaining-time scheduler
// no dependencies
package srtf_pkg;

    localparam int TAG_W = 8;
    localparam int REM_W = 16;
    localparam int TICK_W = 16;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic mode;
        logic [TAG_W-1:0] job_tag;
        logic [REM_W-1:0] burst_length;
    } srtf_item_t;

    typedef struct packed {
        logic [TAG_W-1:0] ran_tag;
        logic busy_res;
        logic job_done;
        logic [TICK_W-1:0] tick_number;
        logic overflow;
    } srtf_result_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [REM_W-1:0] remaining;
    } srtf_entry_t;

    typedef struct packed {
        logic clear;
        logic eval;
    } srtf_best_ctl_t;

    typedef struct packed {
        logic found;
        logic [TAG_W-1:0] tag;
        logic [REM_W-1:0] remaining;
    } srtf_best_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } srtf_state_t;

endpackage

[src/srtf_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module srtf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/srtf_best.sv]
// running minimum tracker: one shared comparator applied to each valid scanned slot
// depends on srtf_pkg
module srtf_best
    import srtf_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  srtf_best_ctl_t           ctl,
    input  logic [$clog2(SLOTS)-1:0] cand_idx,
    input  srtf_entry_t              cand,
    output srtf_best_t               best,
    output logic [$clog2(SLOTS)-1:0] best_idx
);

    localparam int IDX_W = $clog2(SLOTS);

    logic             found_reg, found_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    srtf_entry_t      entry_reg, entry_next;
    logic             take;

    // strict less-than keeps the lowest slot on a tie
    assign take = ctl.eval && (!found_reg || (cand.remaining < entry_reg.remaining));

    always_comb
    begin
        found_next = found_reg;
        idx_next = idx_reg;
        entry_next = entry_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            idx_next = cand_idx;
            entry_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        entry_reg <= entry_next;
    end

    assign best.found = found_reg;
    assign best.tag = entry_reg.tag;
    assign best.remaining = entry_reg.remaining;
    assign best_idx = idx_reg;

endmodule

[src/shortest_remaining_time_scheduler_top.sv]
// top level of the preemptive shortest-remaining-time-first scheduler
// depends on srtf_pkg, srtf_ram, srtf_best
//
// usage
//   command channel: drive item and raise start; the item is taken on a rising
//   edge with start high and busy low. busy stays high while the item is worked
//   item.mode selects an arrival (job tag + burst) or one scheduler tick
//   result channel: strobe is high for one cycle with result valid; the
//   receiver cannot stall, so every result must be taken in that cycle
//   arrivals give no result; an arrival with zero burst is ignored at once,
//   and one that finds no free slot is dropped and sets the sticky overflow
// timing
//   arrival: the free-slot search walks the valid bits one slot per cycle,
//   from slot 0 up until a free slot is found or the last slot is checked
//   tick: the slot table is read one entry per cycle through the ram read
//   port and fed to a single comparator; busy covers the scan, drain and
//   update states, and the strobe rises as busy drops
//   a new item may be accepted in the same cycle the strobe is shown
// reset
//   rst_n clears slot valid bits, the tick counter, the overflow flag and the
//   sequencer; slot contents are not cleared, only valid slots are ever compared
module shortest_remaining_time_scheduler_top
    import srtf_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  srtf_item_t   item,
    output logic         busy,
    output logic         strobe,
    output srtf_result_t result
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int ENTRY_W = $bits(srtf_entry_t);

    // sequencer and bookkeeping
    srtf_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic                drop_flag_reg, drop_flag_next;
    srtf_entry_t         arr_reg, arr_next;
    srtf_result_t        result_reg, result_next;
    logic                strobe_reg, strobe_next;

    // read pipeline: ram data and slot valid are registered and arrive in the cycle after the address
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_vld_reg;

    // ram port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    srtf_entry_t         ram_wdata;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;

    // minimum tracker
    srtf_best_ctl_t      best_ctl;
    srtf_best_t          best;
    logic [IDX_W-1:0]    best_idx;
    logic [REM_W-1:0]    rem_dec;

    srtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    srtf_best #(
        .SLOTS (SLOTS)
    ) u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (best_ctl),
        .cand_idx (rd_idx_reg),
        .cand     (srtf_entry_t'(ram_rdata)),
        .best     (best),
        .best_idx (best_idx)
    );

    assign rem_dec = best.remaining - REM_W'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        valid_next = valid_reg;
        tick_count_next = tick_count_reg;
        drop_flag_next = drop_flag_reg;
        arr_next = arr_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        rd_pend_next = 1'b0;
        ram_we = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = arr_reg;
        ram_re = 1'b0;
        best_ctl.clear = 1'b0;
        best_ctl.eval = rd_pend_reg && rd_vld_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    if (item.mode == MODE_TICK)
                    begin
                        best_ctl.clear = 1'b1;
                        state_next = S_SCAN;
                    end
                    else if (item.burst_length != '0)
                    begin
                        arr_next.tag = item.job_tag;
                        arr_next.remaining = item.burst_length;
                        state_next = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                // lowest free slot wins
                if (!valid_reg[cnt_reg])
                begin
                    ram_we = 1'b1;
                    valid_next[cnt_reg] = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    drop_flag_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            S_SCAN:
            begin
                ram_re = 1'b1;
                rd_pend_next = 1'b1;
                if (cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            S_DRAIN:
            begin
                // last compare lands at the end of this cycle
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                ram_waddr = best_idx;
                ram_wdata.tag = best.tag;
                ram_wdata.remaining = rem_dec;
                ram_we = best.found;
                if (best.found && (rem_dec == '0))
                begin
                    valid_next[best_idx] = 1'b0;
                end
                result_next.ran_tag = best.found ? best.tag : '0;
                result_next.busy_res = best.found;
                result_next.job_done = best.found && (rem_dec == '0);
                result_next.tick_number = tick_count_reg;
                result_next.overflow = drop_flag_reg;
                strobe_next = 1'b1;
                tick_count_next = tick_count_reg + TICK_W'(1);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            tick_count_reg <= '0;
            drop_flag_reg <= 1'b0;
            strobe_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            tick_count_reg <= tick_count_next;
            drop_flag_reg <= drop_flag_next;
            strobe_reg <= strobe_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        arr_reg <= arr_next;
        result_reg <= result_next;
        rd_idx_reg <= cnt_reg;
        rd_vld_reg <= valid_reg[cnt_reg];
    end

    assign busy = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // a result only ever follows the write-back step of a tick
    a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == S_UPDATE))
        else $error("strobe without a preceding update step");

    // an idle tick carries a zero tag and no completion
    a_idle_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !result_reg.busy_res) |-> (result_reg.ran_tag == '0 && !result_reg.job_done))
        else $error("idle tick reports a job");

    // overflow never clears once set
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        drop_flag_reg |=> drop_flag_reg)
        else $error("overflow flag cleared");

    // the slot table is written only while storing an arrival or writing back
    a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_FIND || state_reg == S_UPDATE))
        else $error("slot ram written outside an arrival or write-back");

    // the tick counter moves exactly when a result is produced
    a_tick_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_count_reg != $past(tick_count_reg)) |-> strobe_reg)
        else $error("tick counter moved without a result");
`endif

endmodule
